@@ design/fp12r_pkg.sv @@
// ----------------------------------------------------------------------------
// fp12r_pkg
// Shared types and constants for the binary32 to fp12 rounding converter.
// ----------------------------------------------------------------------------
package fp12r_pkg;

    // Port widths.
    localparam int FLOAT_W = 32;
    localparam int WORD_W  = 16;
    localparam int CODE_W  = 11;

    typedef logic [FLOAT_W-1:0] float_bits_t;
    typedef logic [WORD_W-1:0]  fp12_word_t;
    typedef logic [CODE_W-1:0]  fp12_code_t;

    // Format constants.
    localparam int BIAS32 = 127;
    localparam int BIAS12 = 31;

    localparam logic [7:0]  EXP32_ALL_ONES = 8'hFF;
    localparam logic [7:0]  EXP32_ZERO     = 8'h00;
    localparam fp12_code_t  EXP_ALL_ONES   = 11'h7E0;
    localparam fp12_code_t  NAN_CODE       = 11'h7E1;
    localparam fp12_code_t  ZERO_CODE      = 11'h000;

    // Binary32 exponent field limits for each result range.
    localparam logic [7:0] E8_NORM_MIN   = 8'(BIAS32 + 1 - BIAS12);   // 97
    localparam logic [7:0] E8_NORM_MAX   = 8'(BIAS32 + BIAS12);       // 158
    localparam logic [7:0] E8_SUB_SHBASE = 8'(BIAS32 - 12);           // 115
    localparam logic [7:0] E8_SUB_MIN    = 8'(BIAS32 - 12 - 25);      // 90

    // Mantissa bits dropped when rounding a normal result.
    localparam int NORM_SHIFT = 18;

endpackage

@@ design/float32_to_fp12_round_unit.sv @@
// ----------------------------------------------------------------------------
// float32_to_fp12_round_unit
// Converts binary32 patterns to the 1-6-5 fp12 format, round to nearest even.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle; the input register and the result
// register form a two-stage pipeline that stalls only when both are full.
// Reset (aresetn low, synchronous) empties both stages; payloads keep data.
module float32_to_fp12_round_unit (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  fp12r_pkg::float_bits_t s_float_bits,
    output logic                   m_valid,
    input  logic                   m_ready,
    output fp12r_pkg::fp12_word_t  m_fp12_word
);

    logic                   s1_valid_reg;
    fp12r_pkg::float_bits_t s1_bits_reg;
    logic                   m_valid_reg;
    fp12r_pkg::fp12_word_t  m_word_reg;
    fp12r_pkg::fp12_word_t  conv_word;
    logic                   out_advance;

    // The result stage loads when empty or when its request is taken.
    assign out_advance = !m_valid_reg || m_ready;
    assign s_ready     = !s1_valid_reg || out_advance;

    // Conversion between the input register and the result register.
    fp12r_convert u_convert (
        .float_bits (s1_bits_reg),
        .fp12_word  (conv_word)
    );

    // Pipeline valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                s1_valid_reg <= s_valid;
            end
            if (out_advance) begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Pipeline payloads.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            s1_bits_reg <= s_float_bits;
        end
        if (out_advance && s1_valid_reg) begin
            m_word_reg <= conv_word;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_fp12_word = m_word_reg;

    // The input stage backs up only when both stages hold requests.
    a_ready_low: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (s1_valid_reg && m_valid_reg && !m_ready))
        else $error("input stalled while pipeline had room");

    // An accepted request always lands in the input stage.
    a_accept_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> s1_valid_reg)
        else $error("accepted request lost");

    // The sign copies in the result agree.
    a_sign_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ($countones(m_word_reg[15:11]) == 0 ||
                         $countones(m_word_reg[15:11]) == 5))
        else $error("sign fill bits disagree");

    // Infinity and NaN codes carry a fraction of zero or one only.
    a_special_frac: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_word_reg[10:5] == 6'h3F) |-> (m_word_reg[4:1] == 4'd0))
        else $error("bad fraction on all-ones exponent");

endmodule

@@ design/fp12r_convert.sv @@
// ----------------------------------------------------------------------------
// fp12r_convert
// Combinational binary32 to fp12 conversion with round to nearest, ties to
// even, subnormal results, overflow to infinity and flush of binary32
// subnormals.
// ----------------------------------------------------------------------------
module fp12r_convert (
    input  fp12r_pkg::float_bits_t float_bits,
    output fp12r_pkg::fp12_word_t  fp12_word
);

    logic                  sign;
    logic [7:0]            e8;
    logic [22:0]           frac;
    logic [23:0]           mant;
    logic [5:0]            nq;
    logic                  n_up;
    logic [6:0]            nq_r;
    logic [5:0]            e_off;
    fp12r_pkg::fp12_code_t n_sum;
    logic [4:0]            sh;
    logic [4:0]            sh_m1;
    logic [23:0]           s_low_mask;
    logic [4:0]            sq;
    logic                  s_rbit;
    logic                  s_sticky;
    logic                  s_up;
    logic [5:0]            sq_r;
    fp12r_pkg::fp12_code_t code;

    // Field split.
    assign sign = float_bits[31];
    assign e8   = float_bits[30:23];
    assign frac = float_bits[22:0];
    assign mant = {1'b1, frac};

    // Normal range: keep six mantissa bits, round on the eighteen dropped.
    assign nq    = mant[23:18];
    assign n_up  = mant[17] && ((|mant[16:0]) || mant[18]);
    assign nq_r  = {1'b0, nq} + 7'(n_up);
    assign e_off = 6'(e8 - fp12r_pkg::E8_NORM_MIN);
    assign n_sum = {e_off, 5'd0} + fp12r_pkg::fp12_code_t'(nq_r);

    // Subnormal range: shift of 19 to 25 into units of 2^-35.
    assign sh         = 5'(fp12r_pkg::E8_SUB_SHBASE - e8);
    assign sh_m1      = sh - 5'd1;
    assign s_low_mask = (24'd1 << sh_m1) - 24'd1;
    assign sq         = 5'(mant >> sh);
    assign s_rbit     = mant[sh_m1];
    assign s_sticky   = |(mant & s_low_mask);
    assign s_up       = s_rbit && (s_sticky || sq[0]);
    assign sq_r       = {1'b0, sq} + 6'(s_up);

    // Range selection.
    always_comb begin
        priority if (e8 == fp12r_pkg::EXP32_ALL_ONES) begin
            code = (frac != 23'd0) ? fp12r_pkg::NAN_CODE : fp12r_pkg::EXP_ALL_ONES;
        end else if (e8 == fp12r_pkg::EXP32_ZERO) begin
            code = fp12r_pkg::ZERO_CODE;
        end else if (e8 > fp12r_pkg::E8_NORM_MAX) begin
            code = fp12r_pkg::EXP_ALL_ONES;
        end else if (e8 >= fp12r_pkg::E8_NORM_MIN) begin
            code = (n_sum >= fp12r_pkg::EXP_ALL_ONES) ? fp12r_pkg::EXP_ALL_ONES : n_sum;
        end else if (e8 < fp12r_pkg::E8_SUB_MIN) begin
            code = fp12r_pkg::ZERO_CODE;
        end else begin
            code = fp12r_pkg::fp12_code_t'(sq_r);
        end
    end

    // Sign fills the top five bits.
    assign fp12_word = {{5{sign}}, code};

endmodule

@@ verif/fp12_word_checker.sv @@
// ----------------------------------------------------------------------------
// fp12_word_checker
// Watches both channels of the binary32 to fp12 converter. It predicts each
// fp12 word from the accepted binary32 request and compares it with the word
// that the block returns, oldest first.
// ----------------------------------------------------------------------------
module fp12_word_checker (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  fp12r_pkg::float_bits_t s_float_bits,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  fp12r_pkg::fp12_word_t  m_fp12_word,
    output int                     mismatch_count,
    output int                     outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        fp12r_pkg::float_bits_t source;
        fp12r_pkg::fp12_word_t  word;
    } fp12_expect_t;

    fp12_expect_t expected_words[$];
    fp12_expect_t oldest;
    int           failures = 0;

    // Shift right with round to nearest, ties to even.
    function automatic logic [31:0] round_to_even(logic [23:0] mant, int sh);
        logic [31:0] wide;
        logic [31:0] q;
        logic [31:0] rem;
        logic [31:0] half;
        wide = 32'(mant);
        q    = wide >> sh;
        rem  = wide & ((32'd1 << sh) - 32'd1);
        half = 32'd1 << (sh - 1);
        if (rem > half || (rem == half && q[0])) begin
            q = q + 32'd1;
        end
        return q;
    endfunction

    // Expected fp12 word for one binary32 pattern.
    function automatic fp12r_pkg::fp12_word_t predict_fp12_word(
        fp12r_pkg::float_bits_t bits
    );
        logic [7:0]            e8;
        logic [22:0]           frac;
        int                    code_i;
        fp12r_pkg::fp12_code_t code;
        e8   = bits[30:23];
        frac = bits[22:0];
        if (e8 == fp12r_pkg::EXP32_ALL_ONES) begin
            // Infinity keeps fraction 0; any NaN payload collapses to fraction 1.
            code = (frac != '0) ? fp12r_pkg::NAN_CODE : fp12r_pkg::EXP_ALL_ONES;
        end else if (e8 == fp12r_pkg::EXP32_ZERO) begin
            // Zeros and binary32 subnormals are flushed.
            code = fp12r_pkg::ZERO_CODE;
        end else if (e8 > fp12r_pkg::E8_NORM_MAX) begin
            code = fp12r_pkg::EXP_ALL_ONES;
        end else if (e8 >= fp12r_pkg::E8_NORM_MIN) begin
            // The rounded mantissa is 32..64, so a carry lands in the exponent.
            code_i = (int'(e8) - int'(fp12r_pkg::E8_NORM_MIN)) * 32
                   + int'(round_to_even({1'b1, frac}, fp12r_pkg::NORM_SHIFT));
            code = (code_i >= int'(fp12r_pkg::EXP_ALL_ONES)) ? fp12r_pkg::EXP_ALL_ONES
                                                              : fp12r_pkg::fp12_code_t'(code_i);
        end else if (e8 < fp12r_pkg::E8_SUB_MIN) begin
            code = fp12r_pkg::ZERO_CODE;
        end else begin
            // Subnormal result in units of the smallest subnormal; 32 units
            // reads as the smallest normal.
            code = fp12r_pkg::fp12_code_t'(round_to_even({1'b1, frac},
                       int'(fp12r_pkg::E8_SUB_SHBASE) - int'(e8)));
        end
        return {{(fp12r_pkg::WORD_W - fp12r_pkg::CODE_W){bits[31]}}, code};
    endfunction

    // Record each request, then match each returned word against the oldest.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_words.push_back('{s_float_bits, predict_fp12_word(s_float_bits)});
            end
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected fp12 word %h with no request pending",
                             $time, m_fp12_word);
                    failures++;
                end else begin
                    oldest = expected_words.pop_front();
                    if (m_fp12_word !== oldest.word) begin
                        $display("%0t: fp12 word for %h expected %h actual %h",
                                 $time, oldest.source, oldest.word, m_fp12_word);
                        failures++;
                    end
                end
            end
        end
        mismatch_count <= failures;
        outstanding    <= expected_words.size();
    end

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Drives binary32 requests into the fp12 rounding converter: a directed set of
// format corners first, then random patterns weighted toward the rounding,
// underflow and overflow boundaries. Both sides idle at random, the receiver
// holds off long enough to stall the input, and a checker compares results.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1650;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 10;
    localparam int LIMIT_CYCLES = 600000;

    // Format corners: zeros, flushed subnormals, infinities, NaNs, range
    // edges, ties, the subnormal carry and the underflow threshold.
    localparam fp12r_pkg::float_bits_t CORNER_FLOATS [24] = '{
        32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h807F_FFFF,
        32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'hFF80_0001,
        32'h7F7F_FFFF, 32'h3F80_0000, 32'h4F7C_0000, 32'h4F7E_0000,
        32'h4F80_0000, 32'h3F82_0000, 32'h3F86_0000, 32'h307F_FFFF,
        32'h3080_0000, 32'h2D80_0000, 32'hAD80_0001, 32'h2D7F_FFFF,
        32'h2CFF_FFFF, 32'h2C80_0000, 32'hCF7E_0000, 32'hB07F_FFFF
    };

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    fp12r_pkg::float_bits_t s_float_bits;
    logic                   m_valid;
    logic                   m_ready;
    fp12r_pkg::fp12_word_t  m_fp12_word;

    logic        s_took = 1'b0;
    int          mismatch_count;
    int          outstanding;
    int          cycle_count   = 0;
    int          hold_requests = 0;
    int          hold_served   = 0;

    float32_to_fp12_round_unit i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_float_bits (s_float_bits),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_fp12_word  (m_fp12_word)
    );

    fp12_word_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_float_bits   (s_float_bits),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_fp12_word    (m_fp12_word),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Registered request handshake, read by the driver at the falling edge.
    always @(posedge aclk) begin
        s_took <= aresetn && s_valid && s_ready;
    end

    // Run limit.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("float32_to_fp12_round_unit verification failed");
            $finish;
        end
    end

    // Idle length: mostly none, often short, now and then long.
    function automatic int pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return 0;
        end else if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Random binary32 pattern, weighted toward the interesting exponents,
    // with exact ties and fraction carries forced part of the time.
    function automatic fp12r_pkg::float_bits_t random_float();
        logic [7:0]  e8;
        logic [22:0] frac;
        int unsigned roll;
        int          half_pos;
        roll = $urandom_range(0, 99);
        frac = 23'($urandom);
        if (roll < 10) begin
            e8 = fp12r_pkg::EXP32_ZERO;
        end else if (roll < 18) begin
            e8 = fp12r_pkg::EXP32_ALL_ONES;
        end else if (roll < 32) begin
            e8 = 8'($urandom);
        end else if (roll < 50) begin
            e8 = 8'($urandom_range(86, 98));
        end else begin
            e8 = 8'($urandom_range(95, 160));
        end
        if (e8 >= fp12r_pkg::E8_SUB_MIN && e8 <= fp12r_pkg::E8_NORM_MAX) begin
            half_pos = (e8 >= fp12r_pkg::E8_NORM_MIN)
                     ? fp12r_pkg::NORM_SHIFT - 1
                     : int'(fp12r_pkg::E8_SUB_SHBASE) - int'(e8) - 1;
            if ($urandom_range(0, 7) == 0) begin
                // All ones above the rounding point, so a round-up carries.
                frac = frac | ~((23'd1 << (half_pos + 1)) - 23'd1);
            end
            if ($urandom_range(0, 3) == 0) begin
                // Exactly halfway between two results.
                if (half_pos > 22) begin
                    frac = '0;
                end else begin
                    frac = frac & ~((23'd1 << (half_pos + 1)) - 23'd1);
                    frac[half_pos] = 1'b1;
                end
            end
        end
        return {1'($urandom), e8, frac};
    endfunction

    // Offer one request and return at the falling edge after it is taken.
    task automatic send_request(input fp12r_pkg::float_bits_t bits);
        s_valid      <= 1'b1;
        s_float_bits <= bits;
        @(negedge aclk);
        while (!s_took) @(negedge aclk);
    endtask

    // Stop offering and wait until every expected word has come back.
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        do @(negedge aclk); while (outstanding != 0);
    endtask

    // Receiver: random stalls, calm stretches, and long hold-offs on request.
    initial begin
        int stall;
        m_ready = 1'b0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if (hold_served != hold_requests) begin
                hold_served++;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
            end else if ($urandom_range(0, 49) == 0) begin
                m_ready <= 1'b1;
                repeat ($urandom_range(40, 120)) @(negedge aclk);
            end else begin
                stall = pick_gap();
                if (stall == 0) begin
                    m_ready <= 1'b1;
                    @(negedge aclk);
                end else begin
                    m_ready <= 1'b0;
                    repeat (stall) @(negedge aclk);
                end
            end
        end
    end

    // Sender: reset, directed corners back to back, then random phases.
    initial begin
        int gap;
        bit calm;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_float_bits = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (CORNER_FLOATS[i]) begin
            send_request(CORNER_FLOATS[i]);
        end
        wait_for_drain();

        calm = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 150 == 0) begin
                calm = ($urandom_range(0, 3) == 0);
            end
            // Keep offering requests while the receiver holds off.
            if (n == 500) begin
                hold_requests++;
            end
            if (n == 1000) begin
                wait_for_drain();
            end
            gap = (calm || (n >= 500 && n < 560)) ? 0 : pick_gap();
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            send_request(random_float());
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("float32_to_fp12_round_unit verification clean");
        end else begin
            $display("float32_to_fp12_round_unit verification failed");
        end
        $finish;
    end

endmodule
